@@ rtl/drnjm_pkg.sv @@
// Shared types and constants for the delta-R nearest-jet matcher.
`default_nettype none
package drnjm_pkg;

  localparam int ETA_W      = 14;
  localparam int PHI_W      = 13;
  localparam int DIST_W     = 29;
  localparam int OUT_IDX_W  = 6;
  localparam int PHI_PI     = 3217;
  localparam int PHI_TWO_PI = 6434;

  // Request codes carried on the input tuser.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [1:0] {
    TOK_NONE  = 2'd0,
    TOK_LOAD  = 2'd1,
    TOK_QUERY = 2'd2
  } tok_kind_t;

  // One transaction as it travels down the row of cells.
  typedef struct packed {
    tok_kind_t                kind;
    logic                     first;
    logic signed [ETA_W-1:0]  eta;
    logic signed [PHI_W-1:0]  phi;
    logic                     ovf;
  } tok_t;

endpackage
`default_nettype wire

@@ rtl/drnjm_cell.sv @@
// One cell of the matcher row: holds one jet and updates the running best match.
`default_nettype none
module drnjm_cell #(
  parameter int IW      = 6,
  parameter int CELL_ID = 0
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            adv,
  input  drnjm_pkg::tok_t                tok_in,
  input  wire  [IW-1:0]                  idx_in,
  input  wire  [drnjm_pkg::DIST_W-1:0]   best_in,
  input  wire                            have_in,
  output drnjm_pkg::tok_t                tok_out,
  output logic [IW-1:0]                  idx_out,
  output logic [drnjm_pkg::DIST_W-1:0]   best_out,
  output logic                           have_out
);
  import drnjm_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(CELL_ID);

  logic signed [ETA_W-1:0] jeta;
  logic signed [PHI_W-1:0] jphi;
  logic                    jvalid;

  tok_t              s1_tok;
  logic [IW-1:0]     s1_idx;
  logic [DIST_W-1:0] s1_best;
  logic              s1_have;
  logic [DIST_W-1:0] s1_d;
  logic              s1_hit;

  logic signed [ETA_W:0]   de;
  logic signed [PHI_W:0]   dp_raw;
  logic signed [PHI_W:0]   dp_w;
  logic signed [PHI_W-1:0] dp;
  logic signed [2*ETA_W+1:0] de_sq;
  logic signed [2*PHI_W-1:0] dp_sq;
  logic [DIST_W-1:0]       d;
  logic                    load_here;
  logic                    better;

  always_comb begin
    de     = {tok_in.eta[ETA_W-1], tok_in.eta} - {jeta[ETA_W-1], jeta};
    dp_raw = {tok_in.phi[PHI_W-1], tok_in.phi} - {jphi[PHI_W-1], jphi};
    // A phi difference lies within two pi of the wrapped range, so one step suffices.
    if (dp_raw > (PHI_W+1)'(PHI_PI)) begin
      dp_w = dp_raw - (PHI_W+1)'(PHI_TWO_PI);
    end else if (dp_raw < -(PHI_W+1)'(PHI_PI)) begin
      dp_w = dp_raw + (PHI_W+1)'(PHI_TWO_PI);
    end else begin
      dp_w = dp_raw;
    end
    dp    = dp_w[PHI_W-1:0];
    de_sq = de * de;
    dp_sq = dp * dp;
    d     = de_sq[DIST_W-1:0] + DIST_W'(dp_sq[2*PHI_W-3:0]);
    load_here = (tok_in.kind == TOK_LOAD) && (idx_in == MY_IDX);
    better    = (s1_tok.kind == TOK_QUERY) && s1_hit && (!s1_have || (s1_d < s1_best));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      jvalid        <= 1'b0;
      s1_tok.kind   <= TOK_NONE;
      tok_out.kind  <= TOK_NONE;
    end else if (adv) begin
      if (tok_in.kind == TOK_LOAD) begin
        jvalid <= load_here || (jvalid && !tok_in.first);
      end
      s1_tok.kind  <= tok_in.kind;
      tok_out.kind <= s1_tok.kind;

      if (load_here) begin
        jeta <= tok_in.eta;
        jphi <= tok_in.phi;
      end
      s1_tok.first <= tok_in.first;
      s1_tok.eta   <= tok_in.eta;
      s1_tok.phi   <= tok_in.phi;
      s1_tok.ovf   <= tok_in.ovf;
      s1_idx       <= idx_in;
      s1_best      <= best_in;
      s1_have      <= have_in;
      s1_d         <= d;
      s1_hit       <= jvalid;

      tok_out.first <= s1_tok.first;
      tok_out.eta   <= s1_tok.eta;
      tok_out.phi   <= s1_tok.phi;
      tok_out.ovf   <= s1_tok.ovf;
      if (better) begin
        idx_out  <= MY_IDX;
        best_out <= s1_d;
        have_out <= 1'b1;
      end else begin
        idx_out  <= s1_idx;
        best_out <= s1_best;
        have_out <= s1_have;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/delta_r_nearest_jet_matcher.sv @@
// Top level of the delta-R nearest-jet matcher: entry control, cell row and output register.
//
//   channel  | role          | accepted when            | payload
//   s_axis   | jet or parton | s_axis_tvalid & tready   | tuser: request, first; tdata: eta, phi
//   m_axis   | match result  | m_axis_tvalid & tready   | tdata: index, squared distance, overflow
//
// One transaction is taken per cycle while the output register is empty or being taken. A query
// passes through the row of MAX_JETS cells, two register stages each, to the output register.
// Reset clears the jet count, the overflow flag and every cell's valid bit at once.
// When the output register is full and not taken, the whole row and the input stall together.
`default_nettype none
module delta_r_nearest_jet_matcher #(
  parameter int MAX_JETS = 64
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // [13:0] eta_value, [26:14] phi_value, rest zero
  input  wire  [1:0]  s_axis_tuser,   // [0] req_type, [1] first_of_event
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata    // [5:0] jet_index, [34:6] dist_squared, [35] overflow_seen
);
  import drnjm_pkg::*;

  localparam int IW = (MAX_JETS > 1) ? $clog2(MAX_JETS) : 1;
  localparam int CW = $clog2(MAX_JETS + 1);

  logic [CW-1:0] jet_count;
  logic          overflow_flag;
  logic          adv;
  logic          acc;
  logic          req;
  logic          first;

  tok_t          entry_tok;
  logic [IW-1:0] entry_idx;

  tok_t              chain_tok  [0:MAX_JETS];
  logic [IW-1:0]     chain_idx  [0:MAX_JETS];
  logic [DIST_W-1:0] chain_best [0:MAX_JETS];
  logic              chain_have [0:MAX_JETS];

  logic                 out_hit;
  logic [OUT_IDX_W-1:0] res_idx;
  logic [DIST_W-1:0]    res_dist;
  logic                 res_ovf;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign acc           = s_axis_tvalid && adv;
  assign req           = s_axis_tuser[0];
  assign first         = s_axis_tuser[1];

  always_comb begin
    entry_tok.kind  = TOK_NONE;
    entry_tok.first = first;
    entry_tok.eta   = s_axis_tdata[ETA_W-1:0];
    entry_tok.phi   = s_axis_tdata[ETA_W+PHI_W-1:ETA_W];
    entry_tok.ovf   = overflow_flag;
    entry_idx       = '0;
    if (acc) begin
      if (req == REQ_LOAD) begin
        if (first) begin
          entry_tok.kind = TOK_LOAD;
        end else if (jet_count < CW'(MAX_JETS)) begin
          entry_tok.kind = TOK_LOAD;
          entry_idx      = jet_count[IW-1:0];
        end
      end else if (jet_count != '0) begin
        entry_tok.kind = TOK_QUERY;
      end
    end
  end

  assign chain_tok[0]  = entry_tok;
  assign chain_idx[0]  = entry_idx;
  assign chain_best[0] = '0;
  assign chain_have[0] = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      jet_count     <= '0;
      overflow_flag <= 1'b0;
    end else if (acc && (req == REQ_LOAD)) begin
      if (first) begin
        jet_count     <= CW'(1);
        overflow_flag <= 1'b0;
      end else if (jet_count < CW'(MAX_JETS)) begin
        jet_count <= jet_count + CW'(1);
      end else begin
        overflow_flag <= 1'b1;
      end
    end
  end

  for (genvar g = 0; g < MAX_JETS; g++) begin : g_cell
    drnjm_cell #(
      .IW      (IW),
      .CELL_ID (g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .tok_in   (chain_tok[g]),
      .idx_in   (chain_idx[g]),
      .best_in  (chain_best[g]),
      .have_in  (chain_have[g]),
      .tok_out  (chain_tok[g+1]),
      .idx_out  (chain_idx[g+1]),
      .best_out (chain_best[g+1]),
      .have_out (chain_have[g+1])
    );
  end

  assign out_hit = (chain_tok[MAX_JETS].kind == TOK_QUERY) && chain_have[MAX_JETS];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= out_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && out_hit) begin
      res_idx  <= OUT_IDX_W'(chain_idx[MAX_JETS]);
      res_dist <= chain_best[MAX_JETS];
      res_ovf  <= chain_tok[MAX_JETS].ovf;
    end
  end

  assign m_axis_tdata = {4'b0, res_ovf, res_dist, res_idx};

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for the delta-R nearest-jet matcher.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import drnjm_pkg::*;

  localparam int NUM_JETS = 64;
  localparam int LATENCY  = 2 * NUM_JETS + 1;
  localparam int ITEMS_PER_PHASE = 175;

  typedef struct {
    logic [OUT_IDX_W-1:0] jet_index;
    logic [DIST_W-1:0]    dist_sq;
    logic                 ovf;
  } match_t;

  class match_scoreboard;
    logic signed [ETA_W-1:0] jet_eta [NUM_JETS];
    logic signed [PHI_W-1:0] jet_phi [NUM_JETS];
    int unsigned stored;
    bit          dropped;
    match_t      expected_matches[$];
    int          errors;

    function new();
      stored  = 0;
      dropped = 0;
      errors  = 0;
    endfunction

    function int wrap_dphi(int d);
      while (d > PHI_PI) d -= PHI_TWO_PI;
      while (d < -PHI_PI) d += PHI_TWO_PI;
      return d;
    endfunction

    // Updates the jet store and, for a query on a non-empty store, queues the nearest match.
    function void note_request(logic req, logic first, logic signed [ETA_W-1:0] eta,
                               logic signed [PHI_W-1:0] phi);
      match_t m;
      longint de, dp, d, best_d;
      int     best;
      if (req == REQ_LOAD) begin
        if (first) begin
          stored  = 0;
          dropped = 0;
        end
        if (stored < NUM_JETS) begin
          jet_eta[stored] = eta;
          jet_phi[stored] = phi;
          stored++;
        end else begin
          dropped = 1;
        end
        return;
      end
      if (stored == 0) return;
      best   = 0;
      best_d = 0;
      for (int k = 0; k < stored; k++) begin
        de = longint'(eta) - longint'(jet_eta[k]);
        dp = wrap_dphi(int'(phi) - int'(jet_phi[k]));
        d  = de * de + dp * dp;
        // Strict comparison keeps the lowest index when distances are equal.
        if (k == 0 || d < best_d) begin
          best_d = d;
          best   = k;
        end
      end
      m.jet_index = OUT_IDX_W'(best);
      m.dist_sq   = DIST_W'(best_d);
      m.ovf       = dropped;
      expected_matches.insert(expected_matches.size(), m);
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      errors++;
    endtask

    task check_match(logic [39:0] data);
      match_t               exp_m;
      logic [OUT_IDX_W-1:0] idx;
      logic [DIST_W-1:0]    dsq;
      logic                 ovf;
      idx = data[5:0];
      dsq = data[34:6];
      ovf = data[35];
      if (expected_matches.size() == 0) begin
        report($sformatf("result with nothing pending: index %0d dist %0d", idx, dsq));
        return;
      end
      exp_m = expected_matches.pop_front();
      if (idx !== exp_m.jet_index)
        report($sformatf("jet_index %0d, predicted %0d", idx, exp_m.jet_index));
      if (dsq !== exp_m.dist_sq)
        report($sformatf("dist_squared %0d, predicted %0d", dsq, exp_m.dist_sq));
      if (ovf !== exp_m.ovf)
        report($sformatf("overflow_seen %0b, predicted %0b", ovf, exp_m.ovf));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  match_scoreboard sb;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int sent_items     = 0;
  int hold_left      = 0;
  bit hold_request   = 1'b0;

  delta_r_nearest_jet_matcher #(.MAX_JETS(NUM_JETS)) DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = 400;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      m_axis_tready = 1'b0;
      hold_left--;
    end else begin
      m_axis_tready = ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_match(m_axis_tdata);
  end

  task automatic send_request(logic req, logic first, logic signed [ETA_W-1:0] eta,
                              logic signed [PHI_W-1:0] phi);
    if ($urandom_range(99) < src_idle_pct)
      repeat ($urandom_range(1, 4)) begin
        @(negedge clk);
        s_axis_tvalid = 1'b0;
      end
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = {first, req};
    s_axis_tdata  = {5'd0, phi, eta};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(req, first, eta, phi);
    sent_items++;
  endtask

  function automatic logic signed [ETA_W-1:0] rand_eta();
    int v;
    if ($urandom_range(99) < 30) return ETA_W'($urandom);
    v = int'($urandom_range(0, 4096)) - 2048;
    return ETA_W'(v);
  endfunction

  function automatic logic signed [PHI_W-1:0] rand_phi();
    int v;
    if ($urandom_range(99) < 25) return PHI_W'($urandom);
    v = int'($urandom_range(0, 2 * PHI_PI)) - PHI_PI;
    return PHI_W'(v);
  endfunction

  // One event: a run of jet loads, then partons mostly near one of them, with stray loads.
  task automatic send_event();
    int  n_jets, n_queries, pick, e, p;
    bit  fresh;
    logic signed [ETA_W-1:0] eta, ev_eta[$];
    logic signed [PHI_W-1:0] phi, ev_phi[$];
    // A few events carry on from the previous store without emptying it.
    fresh  = ($urandom_range(99) >= 8);
    n_jets = ($urandom_range(99) < 4) ? $urandom_range(60, 72) : $urandom_range(1, 8);
    for (int j = 0; j < n_jets; j++) begin
      if (j > 0 && $urandom_range(99) < 10) begin
        eta = ev_eta[j-1];
        phi = ev_phi[j-1];
      end else begin
        eta = rand_eta();
        phi = rand_phi();
      end
      ev_eta.insert(ev_eta.size(), eta);
      ev_phi.insert(ev_phi.size(), phi);
      send_request(REQ_LOAD, fresh && j == 0, eta, phi);
    end
    n_queries = $urandom_range(1, 6);
    for (int q = 0; q < n_queries; q++) begin
      if ($urandom_range(99) < 10) send_request(REQ_LOAD, 1'b0, rand_eta(), rand_phi());
      if ($urandom_range(99) < 70) begin
        pick = $urandom_range(0, ev_eta.size() - 1);
        e    = int'(ev_eta[pick]) + int'($urandom_range(0, 128)) - 64;
        p    = int'(ev_phi[pick]) + int'($urandom_range(0, 128)) - 64;
        eta  = ETA_W'(e);
        phi  = PHI_W'(p);
      end else begin
        eta = rand_eta();
        phi = rand_phi();
      end
      send_request(REQ_QUERY, 1'($urandom_range(0, 1)), eta, phi);
    end
  endtask

  initial begin
    int phase_start;
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Queries on an empty store give nothing back.
    send_request(REQ_QUERY, 1'b0, 14'sd0, 13'sd0);
    send_request(REQ_QUERY, 1'b1, -14'sd8192, -13'sd4096);
    // Identical jets: the lower index wins.
    send_request(REQ_LOAD, 1'b1, 14'sd0, 13'sd0);
    send_request(REQ_LOAD, 1'b0, 14'sd0, 13'sd0);
    send_request(REQ_QUERY, 1'b0, 14'sd0, 13'sd0);
    // Field extremes, including patterns outside the nominal ranges.
    send_request(REQ_LOAD, 1'b0, -14'sd8192, -13'sd4096);
    send_request(REQ_LOAD, 1'b0, 14'sd8191, 13'sd4095);
    send_request(REQ_QUERY, 1'b0, 14'sd8191, -13'sd4096);
    send_request(REQ_QUERY, 1'b0, -14'sd8192, 13'sd4095);
    send_request(REQ_QUERY, 1'b0, -14'sd8191, -13'sd3217);
    // Azimuth wrap-around at plus and minus pi.
    send_request(REQ_LOAD, 1'b1, 14'sd0, 13'sd3217);
    send_request(REQ_QUERY, 1'b0, 14'sd0, -13'sd3217);
    send_request(REQ_QUERY, 1'b0, 14'sd0, -13'sd3216);
    send_request(REQ_QUERY, 1'b0, 14'sd0, 13'sd4095);
    send_request(REQ_LOAD, 1'b1, 14'sd100, -13'sd3217);
    send_request(REQ_LOAD, 1'b0, 14'sd100, 13'sd3217);
    send_request(REQ_QUERY, 1'b0, 14'sd100, 13'sd3217);
    // The first-of-event bit means nothing on a query.
    send_request(REQ_QUERY, 1'b1, -14'sd100, 13'sd0);
    send_request(REQ_LOAD, 1'b0, 14'sd8191, 13'sd0);
    send_request(REQ_QUERY, 1'b0, -14'sd8192, 13'sd0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
          // Long receiver hold-off while the sender keeps going, so the row backs up.
          hold_request   = 1'b1;
        end
        1: begin
          src_idle_pct   = 70;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 70;
        end
        default: begin
          src_idle_pct   = 20;
          sink_stall_pct = 20;
        end
      endcase
      phase_start = sent_items;
      while (sent_items - phase_start < ITEMS_PER_PHASE) send_event();
    end
    @(negedge clk);
    s_axis_tvalid = 1'b0;

    while (sb.expected_matches.size() != 0) @(posedge clk);
    repeat (LATENCY + 16) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ files.f @@
rtl/drnjm_pkg.sv
rtl/drnjm_cell.sv
rtl/delta_r_nearest_jet_matcher.sv
dv/tb_top.sv
